/* hdl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 5;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                      enq;
    logic                      deq;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                      occ;   // slot holds an entry
    logic                      gt;    // slot empty or entry > incoming value
    logic signed [VALUE_W-1:0] value;
  } link_t;

endpackage

`default_nettype wire

/* hdl/spq_cell.sv */
// One slot of the sorted row: holds an entry, compares it with the
// incoming value, and takes from its left or right neighbor. Uses spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire spq_pkg::cmd_t  cmd,
  input  wire spq_pkg::link_t left,
  input  wire spq_pkg::link_t right,
  output spq_pkg::link_t      own
);

  logic                               occ;
  logic                               occ_next;
  logic signed [spq_pkg::VALUE_W-1:0] val;
  logic signed [spq_pkg::VALUE_W-1:0] val_next;

  assign own.occ   = occ;
  assign own.value = val;
  assign own.gt    = !occ || (val > cmd.value);

  always_comb begin
    val_next = val;
    occ_next = occ;
    if (cmd.enq) begin
      if (own.gt && !left.gt) begin
        // insertion point: first slot beyond every entry <= value
        val_next = cmd.value;
        occ_next = 1'b1;
      end else if (own.gt && left.gt) begin
        val_next = left.value;
        occ_next = left.occ;
      end
    end else if (cmd.deq) begin
      val_next = right.value;
      occ_next = right.occ;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/sorted_priority_queue.sv */
// Top level of the sorted priority queue: a row of spq_cell slots,
// the entry counter and the result register. Depends on spq_pkg, spq_cell.
`default_nettype none

// Bounded min-priority queue kept as a row of DEPTH cells in ascending
// order. Every cell compares its entry with the incoming value in the same
// cycle, so each command updates the whole row at once: one command per
// cycle, sustained, limited only by the one-deep result register (a new
// transaction is taken whenever that register is empty or being read).
// Enqueue (tuser = 0) puts the value after every entry <= it, so equal
// values leave in arrival order; dequeue (tuser = 1) returns the head.
// Each command yields exactly one result transaction in the cycle after it is
// accepted: status ok / empty (dequeue on empty queue) / full (enqueue
// dropped), the removed value (zero unless a dequeue succeeded) and the
// occupancy after the command (low 5 bits of the count).
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  input  wire logic [0:0]  s_tuser,   // [0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] removed_value, [36:32] occupancy
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::cmd_t  cmd;
  spq_pkg::link_t links [DEPTH];
  spq_pkg::link_t edge_left;
  spq_pkg::link_t edge_right;

  logic                 accept;
  logic                 is_enq;
  logic                 full;
  logic                 empty;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;

  logic                               res_valid;
  spq_pkg::status_t                   res_status;
  spq_pkg::status_t                   res_status_next;
  logic signed [spq_pkg::VALUE_W-1:0] res_value;
  logic signed [spq_pkg::VALUE_W-1:0] res_value_next;
  logic [spq_pkg::OCC_W-1:0]          res_occ;

  // Output register parts the two sides; take input while it drains.
  assign s_tready = !res_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_enq   = (s_tuser[0] == spq_pkg::OP_ENQ);

  // Occupancy is a thermometer across the cells.
  assign full  = links[DEPTH-1].occ;
  assign empty = !links[0].occ;

  assign cmd.enq   = accept && is_enq && !full;
  assign cmd.deq   = accept && !is_enq && !empty;
  assign cmd.value = s_tdata;

  // Ends of the row: left of the head counts as "<= value", right of the
  // tail is an empty slot.
  assign edge_left.occ    = 1'b1;
  assign edge_left.gt     = 1'b0;
  assign edge_left.value  = '0;
  assign edge_right.occ   = 1'b0;
  assign edge_right.gt    = 1'b1;
  assign edge_right.value = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  ((i == 0) ? edge_left : links[(i == 0) ? 0 : i - 1]),
      .right ((i == DEPTH - 1) ? edge_right : links[(i == DEPTH - 1) ? i : i + 1]),
      .own   (links[i])
    );
  end

  always_comb begin
    count_next      = count;
    res_status_next = spq_pkg::ST_OK;
    res_value_next  = '0;
    if (is_enq) begin
      if (full) begin
        res_status_next = spq_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (empty) begin
        res_status_next = spq_pkg::ST_EMPTY;
      end else begin
        count_next     = count - CW'(1);
        res_value_next = links[0].value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= res_status_next;
      res_value  <= res_value_next;
      res_occ    <= spq_pkg::OCC_W'(count_next);
    end
  end

  assign m_tvalid = res_valid;
  assign m_tuser  = res_status;
  assign m_tdata  = {3'b000, res_occ, res_value};

endmodule

`default_nettype wire
